/* design/obb_pkg.sv */
// obb_pkg: shared constants for the opaque bounding box block
// config register indexes, config word width and result field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package obb_pkg;

	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 1;
	localparam int ALPHA_W  = 8;
	localparam int LEFT_W   = 12;
	localparam int SIZE_W   = 13;
	localparam int SAVED_W  = 28;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] RESET_DIM = 13'd64;

endpackage
`default_nettype wire

/* design/obb_cfg.sv */
// obb_cfg: frame size registers and their clamped effective values
// depends on obb_pkg
`timescale 1ns / 1ps
`default_nettype none
module obb_cfg
	import obb_pkg::*;
#(
	parameter int MAX_DIM = 4096,
	parameter int DW = $clog2(MAX_DIM + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic      [DW-1:0]        eff_w,
	output logic      [DW-1:0]        eff_h
);

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	// zero acts as one, oversize clamps to the maximum
	function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (x == 32'd0) begin
			x = 32'd1;
		end else if (x > 32'(MAX_DIM)) begin
			x = 32'(MAX_DIM);
		end
		return DW'(x);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_DIM;
			frame_height_q <= RESET_DIM;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_w = eff_dim(frame_width_q);
	assign eff_h = eff_dim(frame_height_q);

endmodule
`default_nettype wire

/* design/obb_track.sv */
// obb_track: raster counters and opaque extents, registers the box at frame end
// depends on obb_pkg
`timescale 1ns / 1ps
`default_nettype none
module obb_track
	import obb_pkg::*;
#(
	parameter int MAX_DIM = 4096,
	parameter int DW = $clog2(MAX_DIM + 1),
	parameter int CW = $clog2(MAX_DIM)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pix_fire,
	input  wire logic [ALPHA_W-1:0] alpha,
	input  wire logic [DW-1:0]      eff_w,
	input  wire logic [DW-1:0]      eff_h,
	input  wire logic               s1_en,
	output logic                    v_s1,
	output logic      [CW-1:0]      left_s1,
	output logic      [CW-1:0]      top_s1,
	output logic      [DW-1:0]      bw_s1,
	output logic      [DW-1:0]      bh_s1,
	output logic      [DW-1:0]      w_s1,
	output logic      [DW-1:0]      h_s1,
	output logic                    found_s1
);

	logic [CW-1:0] col_q, row_q;
	logic [DW-1:0] least_col_q, col_end_q;
	logic [CW-1:0] least_row_q, great_row_q;
	logic          seen_q;

	logic          opaque, row_end, frame_end, seen_n;
	logic [DW-1:0] col_inc, row_inc, lc_n, ce_n;
	logic [CW-1:0] lr_n, gr_n;

	always_comb begin
		opaque    = alpha != '0;
		col_inc   = DW'(col_q) + DW'(1);
		row_inc   = DW'(row_q) + DW'(1);
		row_end   = !(col_inc < eff_w);
		frame_end = row_end && !(row_inc < eff_h);
		seen_n    = seen_q || opaque;
		lr_n      = (opaque && !seen_q) ? row_q : least_row_q;
		gr_n      = great_row_q;
		if (opaque && (!seen_q || row_q > great_row_q)) begin
			gr_n = row_q;
		end
		lc_n = (opaque && DW'(col_q) < least_col_q) ? DW'(col_q) : least_col_q;
		ce_n = (opaque && col_inc > col_end_q) ? col_inc : col_end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			least_col_q <= '1;
			col_end_q   <= '0;
			least_row_q <= '0;
			great_row_q <= '0;
			seen_q      <= 1'b0;
		end else if (pix_fire) begin
			col_q <= row_end ? '0 : col_inc[CW-1:0];
			if (row_end) begin
				row_q <= frame_end ? '0 : row_inc[CW-1:0];
			end
			if (frame_end) begin
				least_col_q <= '1;
				col_end_q   <= '0;
				least_row_q <= '0;
				great_row_q <= '0;
				seen_q      <= 1'b0;
			end else begin
				least_col_q <= lc_n;
				col_end_q   <= ce_n;
				least_row_q <= lr_n;
				great_row_q <= gr_n;
				seen_q      <= seen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= pix_fire && frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire && frame_end) begin
			found_s1 <= seen_n;
			w_s1     <= eff_w;
			h_s1     <= eff_h;
			if (seen_n) begin
				left_s1 <= lc_n[CW-1:0];
				top_s1  <= lr_n;
				bw_s1   <= ce_n - lc_n;
				bh_s1   <= DW'(gr_n) + DW'(1) - DW'(lr_n);
			end else begin
				left_s1 <= '0;
				top_s1  <= '0;
				bw_s1   <= eff_w;
				bh_s1   <= eff_h;
			end
		end
	end

endmodule
`default_nettype wire

/* design/obb_area.sv */
// obb_area: trim savings products, final sum and the result register
// depends on obb_pkg
`timescale 1ns / 1ps
`default_nettype none
module obb_area
	import obb_pkg::*;
#(
	parameter int MAX_DIM = 4096,
	parameter int DW = $clog2(MAX_DIM + 1),
	parameter int CW = $clog2(MAX_DIM)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              v_s1,
	input  wire logic [CW-1:0]     left_s1,
	input  wire logic [CW-1:0]     top_s1,
	input  wire logic [DW-1:0]     bw_s1,
	input  wire logic [DW-1:0]     bh_s1,
	input  wire logic [DW-1:0]     w_s1,
	input  wire logic [DW-1:0]     h_s1,
	input  wire logic              found_s1,
	input  wire logic              out_ready,
	output logic                   s1_en,
	output logic                   out_valid,
	output logic      [LEFT_W-1:0] box_left,
	output logic      [LEFT_W-1:0] box_top,
	output logic      [SIZE_W-1:0] box_width,
	output logic      [SIZE_W-1:0] box_height,
	output logic      [SAVED_W-1:0] saved_bytes,
	output logic                   found_opaque
);

	localparam int PD = 2 * DW;
	localparam int PW = PD + 3;

	logic          v_s2, out_en, s2_en;
	logic [CW-1:0] left_s2, top_s2;
	logic [DW-1:0] bw_s2, bh_s2;
	logic          found_s2;
	logic [PD-1:0] pw_s2, ph_s2;
	logic [PD-1:0] prod_w, prod_h;
	logic [PW-1:0] saved_sum;

	assign out_en = !out_valid || out_ready;
	assign s2_en  = !v_s2 || out_en;
	assign s1_en  = !v_s1 || s2_en;

	always_comb begin
		prod_w = '0;
		prod_h = '0;
		if (bw_s1 < w_s1) begin
			prod_w = PD'(w_s1 - bw_s1) * PD'(bh_s1);
		end
		if (bh_s1 < h_s1) begin
			prod_h = PD'(h_s1 - bh_s1) * PD'(w_s1);
		end
		saved_sum = (PW'(pw_s2) + PW'(ph_s2)) << 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				out_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && v_s1) begin
			left_s2  <= left_s1;
			top_s2   <= top_s1;
			bw_s2    <= bw_s1;
			bh_s2    <= bh_s1;
			found_s2 <= found_s1;
			pw_s2    <= prod_w;
			ph_s2    <= prod_h;
		end
		if (out_en && v_s2) begin
			box_left     <= LEFT_W'(left_s2);
			box_top      <= LEFT_W'(top_s2);
			box_width    <= SIZE_W'(bw_s2);
			box_height   <= SIZE_W'(bh_s2);
			saved_bytes  <= SAVED_W'(saved_sum);
			found_opaque <= found_s2;
		end
	end

endmodule
`default_nettype wire

/* design/opaque_bounding_box.sv */
// opaque_bounding_box: top level, trim rectangle of the opaque pixels of a frame
// depends on obb_pkg, obb_cfg, obb_track, obb_area
//
// Takes one alpha word per clock in raster order and, after each frame's last
// pixel, returns one word with the trim rectangle, the found flag and the bytes
// that trimming saves at four bytes per pixel. A pixel is accepted every cycle
// while the result pipeline can move; once the frame's last pixel is accepted,
// the result passes the box, product (two savings multipliers) and result
// registers. Frame size registers take effect on the next pixel; the user must
// write them only with the block idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module opaque_bounding_box
	import obb_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ALPHA_W-1:0]   alpha,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [LEFT_W-1:0]    box_left,
	output logic      [LEFT_W-1:0]    box_top,
	output logic      [SIZE_W-1:0]    box_width,
	output logic      [SIZE_W-1:0]    box_height,
	output logic      [SAVED_W-1:0]   saved_bytes,
	output logic                      found_opaque
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CW = $clog2(MAX_DIM);

	logic [DW-1:0] eff_w, eff_h;
	logic          s1_en, v_s1, found_s1;
	logic [CW-1:0] left_s1, top_s1;
	logic [DW-1:0] bw_s1, bh_s1, w_s1, h_s1;

	assign cfg_ready = 1'b1;
	assign in_ready  = s1_en;

	obb_cfg #(.MAX_DIM(MAX_DIM), .DW(DW)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.eff_w     (eff_w),
		.eff_h     (eff_h)
	);

	obb_track #(.MAX_DIM(MAX_DIM), .DW(DW), .CW(CW)) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_fire (in_valid && in_ready),
		.alpha    (alpha),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.s1_en    (s1_en),
		.v_s1     (v_s1),
		.left_s1  (left_s1),
		.top_s1   (top_s1),
		.bw_s1    (bw_s1),
		.bh_s1    (bh_s1),
		.w_s1     (w_s1),
		.h_s1     (h_s1),
		.found_s1 (found_s1)
	);

	obb_area #(.MAX_DIM(MAX_DIM), .DW(DW), .CW(CW)) u_area (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s1         (v_s1),
		.left_s1      (left_s1),
		.top_s1       (top_s1),
		.bw_s1        (bw_s1),
		.bh_s1        (bh_s1),
		.w_s1         (w_s1),
		.h_s1         (h_s1),
		.found_s1     (found_s1),
		.out_ready    (out_ready),
		.s1_en        (s1_en),
		.out_valid    (out_valid),
		.box_left     (box_left),
		.box_top      (box_top),
		.box_width    (box_width),
		.box_height   (box_height),
		.saved_bytes  (saved_bytes),
		.found_opaque (found_opaque)
	);

endmodule
`default_nettype wire

/* sim/tb_opaque_bounding_box.sv */
// tb_opaque_bounding_box: self-checking testbench for the opaque bounding box block
// streams alpha frames over valid/ready, predicts each trim box and compares it per field
// depends on obb_pkg and opaque_bounding_box
`timescale 1ns / 1ps
module tb_opaque_bounding_box;
	import obb_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int MAX_REPORTS = 10;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SMALL_PIXELS = 2000;
	localparam int BIG_FRAME = 1000;

	typedef struct {
		logic [LEFT_W-1:0]  left_col;
		logic [LEFT_W-1:0]  top_row;
		logic [SIZE_W-1:0]  span_w;
		logic [SIZE_W-1:0]  span_h;
		logic [SAVED_W-1:0] saved;
		logic               found;
	} trim_box_t;

	typedef enum {FILL_CLEAR, FILL_SPARSE, FILL_DENSE, FILL_RECT} fill_t;

	class trim_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		int unsigned col, row, least_col, col_end, least_row, greatest_row;
		bit seen;
		trim_box_t pending_q[$];
		int errors;
		int reported;

		function new();
			width_reg = RESET_DIM;
			height_reg = RESET_DIM;
			errors = 0;
			reported = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			col = 0;
			row = 0;
			least_col = 13'h1fff;
			col_end = 0;
			least_row = 0;
			greatest_row = 0;
			seen = 1'b0;
		endfunction

		function int unsigned eff_dim(logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_FRAME_WIDTH)
				width_reg = data;
			else
				height_reg = data;
		endfunction

		// one accepted pixel; pushes the trim box when it closes the frame
		function void note_pixel(logic [ALPHA_W-1:0] a);
			int unsigned wf, hf, c, r;
			longint unsigned bw, bh, sv;
			trim_box_t res;
			wf = eff_dim(width_reg);
			hf = eff_dim(height_reg);
			c = col;
			r = row;
			if (a != 0) begin
				if (!seen) begin
					least_row = r;
					greatest_row = r;
				end
				seen = 1'b1;
				if (c < least_col)
					least_col = c;
				if (c + 1 > col_end)
					col_end = c + 1;
				if (r > greatest_row)
					greatest_row = r;
			end
			if (c + 1 < wf) begin
				col = c + 1;
				return;
			end
			col = 0;
			if (r + 1 < hf) begin
				row = r + 1;
				return;
			end
			if (seen) begin
				res.left_col = LEFT_W'(least_col);
				res.top_row = LEFT_W'(least_row);
				bw = longint'(col_end) - least_col;
				bh = longint'(greatest_row) + 1 - least_row;
			end else begin
				res.left_col = '0;
				res.top_row = '0;
				bw = wf;
				bh = hf;
			end
			sv = 0;
			if (bw < wf)
				sv += (longint'(wf) - bw) * bh;
			if (bh < hf)
				sv += (longint'(hf) - bh) * wf;
			sv *= 4;
			res.span_w = bw[SIZE_W-1:0];
			res.span_h = bh[SIZE_W-1:0];
			res.saved = sv[SAVED_W-1:0];
			res.found = seen;
			pending_q.push_back(res);
			clear_frame();
		endfunction

		function string fmt(trim_box_t b);
			return $sformatf("left %0d top %0d width %0d height %0d saved %0d found %0b",
				b.left_col, b.top_row, b.span_w, b.span_h, b.saved, b.found);
		endfunction

		function void note_error(string msg);
			errors++;
			if (reported < MAX_REPORTS) begin
				reported++;
				$display("[%0t] mismatch: %s", $time, msg);
			end
		endfunction

		function void check_result(trim_box_t got);
			trim_box_t want;
			if (pending_q.size() == 0) begin
				note_error({"unexpected word: ", fmt(got)});
				return;
			end
			want = pending_q.pop_front();
			if (got.left_col !== want.left_col || got.top_row !== want.top_row ||
					got.span_w !== want.span_w || got.span_h !== want.span_h ||
					got.saved !== want.saved || got.found !== want.found)
				note_error({"expected ", fmt(want), " got ", fmt(got)});
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic [ALPHA_W-1:0]   alpha = '0;
	logic                 out_ready = 1'b0;
	logic                 cfg_ready;
	logic                 in_ready;
	logic                 out_valid;
	logic [LEFT_W-1:0]    box_left;
	logic [LEFT_W-1:0]    box_top;
	logic [SIZE_W-1:0]    box_width;
	logic [SIZE_W-1:0]    box_height;
	logic [SAVED_W-1:0]   saved_bytes;
	logic                 found_opaque;

	trim_scoreboard sb;
	int send_idle = 15;
	int recv_idle = 87;
	int stall_cycles = 0;

	opaque_bounding_box #(.MAX_DIM(MAX_DIM)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.alpha        (alpha),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.box_left     (box_left),
		.box_top      (box_top),
		.box_width    (box_width),
		.box_height   (box_height),
		.saved_bytes  (saved_bytes),
		.found_opaque (found_opaque)
	);

	always #5 clk = ~clk;

	// result side: check each accepted word, random back-pressure
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result('{box_left, box_top, box_width, box_height, saved_bytes,
				found_opaque});
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
		write_reg(REG_FRAME_WIDTH, w_val);
		write_reg(REG_FRAME_HEIGHT, h_val);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [ALPHA_W-1:0] a);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		alpha <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_pixel(a);
	endtask

	// wait for every trim box, then let the result pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic send_frame(input int unsigned wf, input int unsigned hf, input fill_t fill);
		int unsigned x0, x1, y0, y1, odds;
		bit opaque;
		x0 = $urandom_range(0, wf - 1);
		x1 = $urandom_range(x0, wf - 1);
		y0 = $urandom_range(0, hf - 1);
		y1 = $urandom_range(y0, hf - 1);
		odds = (wf * hf > BIG_FRAME) ? 800 : 12;
		for (int unsigned r = 0; r < hf; r++) begin
			for (int unsigned c = 0; c < wf; c++) begin
				case (fill)
					FILL_CLEAR: opaque = 1'b0;
					FILL_SPARSE: opaque = ($urandom_range(0, odds - 1) == 0);
					FILL_DENSE: opaque = 1'($urandom_range(0, 1));
					default: opaque = (c >= x0 && c <= x1 && r >= y0 && r <= y1 &&
						$urandom_range(0, 3) != 0);
				endcase
				send_pixel(opaque ? ALPHA_W'($urandom_range(1, 255)) : '0);
			end
		end
	endtask

	initial begin
		// 3x2 frames: lone pixel at column 0 of the last row, then a diagonal pair
		logic [ALPHA_W-1:0] corner_frames [12] = '{8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00,
			8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h04};
		logic [CFG_W-1:0] w_val, h_val;
		int unsigned small_total, wf, hf, nframes;
		sb = new();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-sized registers act as a 1x1 frame
		set_frame('0, '0);
		send_pixel(8'h00);
		send_pixel(8'hff);
		send_pixel(8'h01);
		send_pixel(8'h80);
		drain();
		set_frame(13'd3, 13'd2);
		foreach (corner_frames[i])
			send_pixel(corner_frames[i]);
		drain();

		small_total = 0;
		while (small_total < SMALL_PIXELS) begin
			drain();
			if (small_total < SMALL_PIXELS / 3) begin
				send_idle = 15;
				recv_idle = 87;
			end else if (small_total < 2 * SMALL_PIXELS / 3) begin
				send_idle = 87;
				recv_idle = 15;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			w_val = CFG_W'($urandom_range(0, 12));
			h_val = CFG_W'($urandom_range(0, 8));
			set_frame(w_val, h_val);
			wf = sb.eff_dim(w_val);
			hf = sb.eff_dim(h_val);
			nframes = (wf * hf > BIG_FRAME) ? 1 : $urandom_range(2, 6);
			repeat (nframes)
				send_frame(wf, hf, fill_t'($urandom_range(0, 3)));
			if (wf * hf <= BIG_FRAME)
				small_total += nframes * wf * hf;
		end
		drain();

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
design/obb_pkg.sv
design/obb_cfg.sv
design/obb_track.sv
design/obb_area.sv
design/opaque_bounding_box.sv
sim/tb_opaque_bounding_box.sv
